/* src/ppmd_pkg.sv */
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared types and constants of the position PID motor drive.
// ----------------------------------------------------------------------------
`default_nettype none
package ppmd_pkg;

  localparam int unsigned PosW = 24;
  localparam int unsigned ErrW = PosW + 2;
  localparam int unsigned PwrW = 11;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = 1;

  // ceil(2^26 / 5): (x * Rcp5) >> 26 is x / 5 for any 24-bit x
  localparam logic [23:0] Rcp5 = 24'd13421773;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_TARGET  = 3'd1,
    OP_POWER   = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_NONE    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_PLIMIT  = 3'd3,
    REG_PIDMODE = 3'd4,
    REG_TIMEOUT = 3'd5
  } reg_e;

  typedef struct packed {
    op_e               op;
    logic signed [PosW-1:0] value;
    logic signed [PosW-1:0] position;
    logic              pid_due;
    logic              fault_ok;
    logic              lower;
    logic              upper;
    logic [31:0]       time_ms;
  } cmd_t;

  typedef struct packed {
    logic [9:0] pwm_duty;
    logic       dir_fwd;
    logic       enabled;
    logic       fault;
    logic       enc_reset;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV_H, ST_DIV_R, ST_DIV_L, ST_SUM, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    TERM_P, TERM_I, TERM_D
  } term_e;

endpackage
`default_nettype wire

/* src/ppmd_front.sv */
// ----------------------------------------------------------------------------
// ppmd_front
// Decodes incoming items and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module ppmd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [2:0]          op_i,
  input  wire logic [23:0]         value_i,
  input  wire logic [23:0]         position_i,
  input  wire logic                pid_due_i,
  input  wire logic                fault_ok_i,
  input  wire logic                lower_i,
  input  wire logic                upper_i,
  input  wire logic [31:0]         time_ms_i,
  output ppmd_pkg::cmd_t           cmd_o,
  output logic                     cmd_valid_o,
  input  wire logic                cmd_take_i
);
  import ppmd_pkg::*;

  cmd_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  cmd_t             in_cmd;
  logic             do_push, do_pop;

  assign full_o = (cnt_q == (QPtrW+1)'(QDepth));
  assign do_push = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop = cmd_take_i && cmd_valid_o;
  assign cmd_o = q_mem[rd_q];

  always_comb begin
    in_cmd.op = (op_i > 3'd4) ? OP_NONE : op_e'(op_i);
    in_cmd.value = value_i;
    in_cmd.position = position_i;
    in_cmd.pid_due = pid_due_i;
    in_cmd.fault_ok = fault_ok_i;
    in_cmd.lower = lower_i;
    in_cmd.upper = upper_i;
    in_cmd.time_ms = time_ms_i;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrW+1)'(QDepth)) else $error("queue count overflow");
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == $past(cnt_q)) else $error("push while full");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 && !do_push |=> cnt_q == '0) else $error("pop while empty");

endmodule
`default_nettype wire

/* src/ppmd_back.sv */
// ----------------------------------------------------------------------------
// ppmd_back
// Carries out commands: state updates, PID terms on a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module ppmd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  ppmd_pkg::cmd_t           cmd_i,
  input  wire logic                cmd_valid_i,
  output logic                     cmd_take_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [15:0]         cfg_data_i,
  output ppmd_pkg::res_t           res_o,
  output logic                     res_valid_o,
  input  wire logic                res_take_i
);
  import ppmd_pkg::*;

  logic [15:0] gp_q, gi_q, gd_q, to_q;
  logic [9:0]  plim_q;
  logic        mode_q;
  logic signed [PosW-1:0] tgt_q, tgt_d;
  logic signed [ErrW-1:0] perr_q, perr_d, err_q, err_d, dp_q, dp_d;
  logic signed [PwrW-1:0] integ_q, integ_d, pwr_q, pwr_d;
  logic        en_q, en_d, flt_q, flt_d, dir_q, dir_d, enc_q, enc_d;
  logic [31:0] lct_q, lct_d;
  logic signed [45:0] acc_q, acc_d;
  state_e      st_q, st_d;
  term_e       term_q, term_d;
  logic [41:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [20:0] qh_q, qh_d;
  logic [4:0]  rem_q, rem_d;
  logic        res_v_q, res_v_d;
  res_t        res_q, res_d;
  logic        lim_lo_q;

  logic signed [ErrW-1:0] mul_a;
  logic [15:0]            mul_b;
  logic signed [42:0]     prod;
  logic [23:0]            rcp_x;
  logic [47:0]            rcp_p;
  logic [41:0]            quo;
  logic [31:0]            elapsed;
  logic signed [ErrW:0]   isum;
  logic signed [PosW:0]   jump;
  logic [ErrW-1:0]        emag;
  logic signed [PwrW-1:0] pw, negp;
  logic signed [PosW-1:0] vcl;
  logic signed [10:0]     plim_s;
  logic signed [PwrW:0]   pneg;
  logic [10:0]            pmag;

  assign res_o = res_q;
  assign res_valid_o = res_v_q;
  assign prod = mul_a * $signed({1'b0, mul_b});
  // divide by 20: magnitude split in two 21-bit halves, each half by reciprocal
  assign rcp_p = rcp_x * Rcp5;
  assign quo = {qh_q, rcp_p[46:26]};
  assign elapsed = cmd_i.time_ms - lct_q;
  assign emag = err_q[ErrW-1] ? ErrW'(-err_q) : err_q;
  assign plim_s = {1'b0, plim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q <= '0; gi_q <= '0; gd_q <= '0; plim_q <= 10'd1023;
      mode_q <= 1'b0; to_q <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_P:  gp_q <= cfg_data_i;
        REG_GAIN_I:  gi_q <= cfg_data_i;
        REG_GAIN_D:  gd_q <= cfg_data_i;
        REG_PLIMIT:  plim_q <= cfg_data_i[9:0];
        REG_PIDMODE: mode_q <= cfg_data_i[0];
        REG_TIMEOUT: to_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; tgt_q <= '0; perr_q <= '0; integ_q <= '0; pwr_q <= '0;
      en_q <= 1'b0; flt_q <= 1'b0; dir_q <= 1'b1; enc_q <= 1'b0; lct_q <= '0;
      res_v_q <= 1'b0; err_q <= '0; dp_q <= '0; acc_q <= '0; res_q <= '0;
      term_q <= TERM_P; mag_q <= '0; neg_q <= 1'b0; qh_q <= '0; rem_q <= '0;
    end else begin
      st_q <= st_d; tgt_q <= tgt_d; perr_q <= perr_d; integ_q <= integ_d;
      pwr_q <= pwr_d; en_q <= en_d; flt_q <= flt_d; dir_q <= dir_d;
      enc_q <= enc_d; lct_q <= lct_d; res_v_q <= res_v_d; err_q <= err_d;
      dp_q <= dp_d; acc_q <= acc_d; res_q <= res_d;
      term_q <= term_d; mag_q <= mag_d; neg_q <= neg_d; qh_q <= qh_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    st_d = st_q; tgt_d = tgt_q; perr_d = perr_q; integ_d = integ_q;
    pwr_d = pwr_q; en_d = en_q; flt_d = flt_q; dir_d = dir_q; enc_d = enc_q;
    lct_d = lct_q; err_d = err_q; dp_d = dp_q; acc_d = acc_q;
    res_d = res_q; res_v_d = res_v_q;
    term_d = term_q; mag_d = mag_q; neg_d = neg_q; qh_d = qh_q; rem_d = rem_q;
    cmd_take_o = 1'b0;
    mul_a = err_q; mul_b = gp_q;
    rcp_x = {5'd0, mag_q[41:23]};
    isum = '0; jump = '0; vcl = '0; pw = '0; negp = '0; pneg = '0; pmag = '0;
    if (res_take_i && res_v_q) res_v_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          enc_d = 1'b0;
          st_d = ST_OUT;
          case (cmd_i.op)
            OP_TICK: begin
              pw = pwr_q;
              if (!mode_q && elapsed > {16'd0, to_q}) pw = '0;
              if (!cmd_i.fault_ok) begin
                pw = '0; en_d = 1'b0; flt_d = 1'b1;
              end
              pwr_d = pw;
              enc_d = cmd_i.upper;
              if (mode_q && cmd_i.pid_due) begin
                err_d = ErrW'(cmd_i.position) - ErrW'(tgt_q);
                dp_d = err_d - perr_q;
                perr_d = err_d;
                acc_d = '0;
                term_d = TERM_P;
                st_d = ST_MUL;
              end else begin
                if (cmd_i.lower) begin
                  if (tgt_q < 0) tgt_d = '0;
                  if (pw < 0) pwr_d = '0;
                end
                if (cmd_i.upper && pw > 0) pwr_d = '0;
              end
            end
            OP_TARGET: begin
              jump = (PosW+1)'(tgt_q) - (PosW+1)'(cmd_i.value);
              if (jump > 100 || jump < -100) integ_d = '0;
              tgt_d = cmd_i.value;
            end
            OP_POWER: begin
              lct_d = cmd_i.time_ms;
              if (en_q) begin
                vcl = cmd_i.value;
                if (vcl > PosW'(plim_s)) pwr_d = plim_s;
                else if (vcl < -PosW'(plim_s)) pwr_d = -plim_s;
                else pwr_d = PwrW'(vcl);
              end
            end
            OP_ENABLE: begin en_d = 1'b1; flt_d = 1'b0; end
            OP_DISABLE: en_d = 1'b0;
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        case (term_q)
          TERM_I: begin mul_a = ErrW'(integ_q); mul_b = gi_q; end
          TERM_D: begin mul_a = dp_q; mul_b = gd_q; end
          default: ;
        endcase
        if (term_q == TERM_P && emag > ErrW'(4)) begin
          isum = (ErrW+1)'(integ_q) + (ErrW+1)'(err_q);
          if (isum > 768) integ_d = 11'sd768;
          else if (isum < -768) integ_d = -11'sd768;
          else integ_d = PwrW'(isum);
        end
        neg_d = prod[42];
        mag_d = prod[42] ? 42'(-prod) : 42'(prod);
        st_d = ST_DIV_H;
      end
      ST_DIV_H: begin
        qh_d = rcp_p[46:26];
        st_d = ST_DIV_R;
      end
      ST_DIV_R: begin
        rem_d = 5'(mag_q[41:21] - {qh_q[16:0], 4'd0} - {qh_q[18:0], 2'd0});
        st_d = ST_DIV_L;
      end
      ST_DIV_L: begin
        rcp_x = {rem_q, mag_q[20:2]};
        acc_d = neg_q ? acc_q - $signed(46'(quo)) : acc_q + $signed(46'(quo));
        if (term_q == TERM_D) st_d = ST_SUM;
        else begin
          term_d = (term_q == TERM_P) ? TERM_I : TERM_D;
          st_d = ST_MUL;
        end
      end
      ST_SUM: begin
        if (emag < ErrW'(4)) pw = '0;
        else if (acc_q > 512) pw = 11'sd512;
        else if (acc_q < -512) pw = -11'sd512;
        else pw = PwrW'(acc_q);
        pwr_d = pw;
        st_d = ST_OUT;
        // limit checks use stored switch state of this tick
        if (lim_lo_q) begin
          if (tgt_q < 0) tgt_d = '0;
          if (pw < 0) pwr_d = '0;
        end
        if (enc_q && pw > 0) pwr_d = '0;
      end
      ST_OUT: begin
        if (!res_v_q || res_take_i) begin
          negp = -pwr_q;
          pneg = -(PwrW+1)'(pwr_q);
          pmag = pneg[PwrW] ? PwrW'(-pneg) : PwrW'(pneg);
          res_d.enc_reset = enc_q;
          res_d.enabled = en_q;
          res_d.fault = flt_q;
          res_d.dir_fwd = dir_q;
          res_d.pwm_duty = '0;
          if (pwr_q != '0 && en_q) begin
            dir_d = negp > 0;
            res_d.dir_fwd = negp > 0;
            res_d.pwm_duty = (pmag > 11'd1023) ? 10'd1023 : pmag[9:0];
          end
          res_v_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lim_lo_q <= 1'b0;
    else if (st_q == ST_IDLE && cmd_valid_i) lim_lo_q <= cmd_i.lower;
  end

  a_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q <= 768 && integ_q >= -768) else $error("integral out of range");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> st_q == ST_IDLE) else $error("take outside idle");
  a_pwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_OUT && $past(st_q) == ST_SUM |-> pwr_q <= 512 && pwr_q >= -512)
    else $error("pid power out of range");

endmodule
`default_nettype wire

/* src/position_pid_motor_drive.sv */
// ----------------------------------------------------------------------------
// position_pid_motor_drive
// Position PID motor drive with anti-windup, manual power and limit switches.
//
// Input items are pushed with push while full is low; a two-entry
// command queue decouples decoding from execution. Each item yields one
// result, read from the result register while empty is low and taken
// with pop. A non-PID item goes from the queue head straight to the
// output step; a PID tick runs three terms (a 26x17 multiply, then a
// divide by twenty as two reciprocal multiplies on 21-bit halves), then
// a clamp step and the output step. The back end takes a new item only
// when the last is done, and accepts one while a result waits; when the
// receiver stalls, the back end holds at its output step and the queue
// fills, then full rises. Reset sets all registers but the queue store:
// gains 0, power limit 1023, timeout 1000, direction forward. The user
// writes configuration with cfg_we_i, cfg_idx_i and cfg_data_i only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module position_pid_motor_drive (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  operation_i,
  input  wire logic [23:0] value_i,
  input  wire logic [23:0] position_i,
  input  wire logic        pid_due_i,
  input  wire logic        fault_ok_i,
  input  wire logic        lower_limit_hit_i,
  input  wire logic        upper_limit_hit_i,
  input  wire logic [31:0] time_ms_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [9:0]       pwm_duty_o,
  output logic             direction_forward_o,
  output logic             motor_enabled_o,
  output logic             fault_indicator_o,
  output logic             encoder_reset_request_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import ppmd_pkg::*;

  cmd_t        cmd;
  res_t        res;
  logic        cmd_valid, cmd_take, res_valid;

  ppmd_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .op_i(operation_i),
    .value_i, .position_i, .pid_due_i, .fault_ok_i,
    .lower_i(lower_limit_hit_i), .upper_i(upper_limit_hit_i), .time_ms_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take)
  );

  ppmd_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid),
    .cmd_take_o(cmd_take), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_o(res), .res_valid_o(res_valid), .res_take_i(pop)
  );

  assign empty = !res_valid;
  assign pwm_duty_o = res.pwm_duty;
  assign direction_forward_o = res.dir_fwd;
  assign motor_enabled_o = res.enabled;
  assign fault_indicator_o = res.fault;
  assign encoder_reset_request_o = res.enc_reset;

endmodule
`default_nettype wire
